FILE: hw/rtl/wsf_pkg.sv
// Shared types, constants and helpers for the waypoint step follower.
package wsf_pkg;

	localparam int PW              = 32;
	localparam int CFG_DW          = 24;
	localparam int CFG_IW          = 3;
	localparam int WPW             = 6;
	localparam int MAX_WAYPOINTS_D = 32;
	localparam int SQRT_STEPS      = 31;
	localparam int DIV_STEPS       = 54;
	localparam int ITW             = 6;
	localparam logic [48:0] NEAR_ZERO_SQ = 49'd4295;

	localparam logic [CFG_IW-1:0] REG_MAX_STEP   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_REACH_TH   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ALT_TOL    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ALT_OFFSET = 3'd3;
	localparam logic [CFG_IW-1:0] REG_HOLD_TICKS = 3'd4;
	localparam logic [CFG_IW-1:0] REG_WP_COUNT   = 3'd5;
	localparam logic [CFG_IW-1:0] REG_WARMUP     = 3'd6;

	typedef enum logic [2:0] {
		ACT_HEARTBEAT = 3'd0,
		ACT_SETPOINT  = 3'd1,
		ACT_OFFBOARD  = 3'd2,
		ACT_ARM       = 3'd3,
		ACT_DONE      = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_INIT     = 2'd0,
		MODE_OFFBOARD = 2'd1,
		MODE_ARMED    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_POS  = 2'd1,
		SEL_TGT  = 2'd2,
		SEL_STEP = 2'd3
	} sp_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVAL, ST_TGT, ST_CHK, ST_SQ, ST_CMP, ST_NORM, ST_MUL,
		ST_SINIT, ST_SQRT, ST_DINIT_A, ST_DIVA, ST_DINIT_B, ST_DIVB, ST_APPLY, ST_OUT
	} state_t;

	typedef struct packed {
		logic [23:0]        step_len;
		logic [23:0]        reach_th;
		logic [23:0]        alt_tol;
		logic signed [23:0] alt_offset;
		logic [15:0]        hold_ticks;
		logic [5:0]         wp_count;
		logic [7:0]         warmup;
	} cfg_t;

	typedef struct packed {
		logic           accept;
		logic [WPW-1:0] rd_wp;
		logic           anchor_cap;
		logic           tgt_en;
		logic           diff_en;
		logic           sq_en;
		logic           norm_en;
		logic           mul_en;
		logic           sqrt_init;
		logic           sqrt_step;
		logic           div_init;
		logic           div_sel_b;
		logic           div_step;
		logic           qa_store;
		logic           apply_en;
		logic           out_load;
		action_t        out_act;
		sp_sel_t        out_sel;
		logic [WPW-1:0] out_wp;
		logic           out_hold;
	} cmd_t;

	typedef struct packed {
		logic odom_seen;
		logic gate_ok;
		logic near;
		logic reach;
		logic r_zero;
		logic out_busy;
	} sts_t;

	function automatic logic [PW-1:0] sat_pos(input logic [PW:0] v);
		logic [PW-1:0] res;
		if (v[PW] != v[PW-1])
			res = v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		else
			res = v[PW-1:0];
		return res;
	endfunction

endpackage

FILE: hw/rtl/wsf_cfg.sv
// Configuration register bank.
module wsf_cfg
	import wsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_len   <= 24'd32768;
			cfg_q.reach_th   <= 24'd6554;
			cfg_q.alt_tol    <= 24'd19661;
			cfg_q.alt_offset <= 24'sd327680;
			cfg_q.hold_ticks <= 16'd50;
			cfg_q.wp_count   <= 6'd11;
			cfg_q.warmup     <= 8'd10;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_STEP:   cfg_q.step_len   <= cfg_data;
				REG_REACH_TH:   cfg_q.reach_th   <= cfg_data;
				REG_ALT_TOL:    cfg_q.alt_tol    <= cfg_data;
				REG_ALT_OFFSET: cfg_q.alt_offset <= cfg_data;
				REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data[15:0];
				REG_WP_COUNT:   cfg_q.wp_count   <= cfg_data[5:0];
				REG_WARMUP:     cfg_q.warmup     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/wsf_ctrl.sv
// Sequencer: mission state, warm-up, hold and the step computation order.
module wsf_ctrl
	import wsf_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  cfg_t cfg,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t         state_q, state_d;
	mode_t          mode_q, mode_d;
	logic [7:0]     warm_q, warm_d;
	logic [WPW-1:0] wp_q, wp_d;
	logic           anchor_set_q, anchor_set_d;
	logic           hold_q, hold_d;
	logic [15:0]    hold_cnt_q, hold_cnt_d;
	action_t        act_q, act_d;
	sp_sel_t        sel_q, sel_d;
	logic [ITW-1:0] iter_q, iter_d;

	logic [8:0]  wp_lim;
	logic        wp_done;
	logic        warm_active;
	logic        accept;
	logic [15:0] hc_inc;

	// waypoint_count above the table depth acts as the depth
	assign wp_lim = ({3'b0, cfg.wp_count} > 9'(MAX_WAYPOINTS)) ?
		9'(MAX_WAYPOINTS) : {3'b0, cfg.wp_count};
	assign wp_done     = {3'b0, wp_q} >= wp_lim;
	assign warm_active = warm_q < cfg.warmup;
	assign accept      = in_valid && (state_q == ST_IDLE);
	assign in_stall    = (state_q != ST_IDLE);
	assign hc_inc      = hold_cnt_q + {15'b0, (hold_cnt_q != 16'hFFFF)};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept && !req_type) state_d = ST_EVAL;
			ST_EVAL: begin
				if (warm_active || mode_q != MODE_ARMED || wp_done)
					state_d = ST_OUT;
				else
					state_d = ST_TGT;
			end
			ST_TGT:     state_d = ST_CHK;
			ST_CHK:     state_d = ST_SQ;
			ST_SQ:      state_d = ST_CMP;
			ST_CMP: begin
				if ((wp_q == WPW'(1) && !sts.gate_ok) || sts.near)
					state_d = ST_OUT;
				else
					state_d = ST_NORM;
			end
			ST_NORM:    state_d = ST_MUL;
			ST_MUL:     state_d = ST_SINIT;
			ST_SINIT:   state_d = ST_SQRT;
			ST_SQRT:    if (iter_q == ITW'(SQRT_STEPS - 1)) state_d = ST_DINIT_A;
			ST_DINIT_A: state_d = sts.r_zero ? ST_OUT : ST_DIVA;
			ST_DIVA:    if (iter_q == ITW'(DIV_STEPS - 1)) state_d = ST_DINIT_B;
			ST_DINIT_B: state_d = ST_DIVB;
			ST_DIVB:    if (iter_q == ITW'(DIV_STEPS - 1)) state_d = ST_APPLY;
			ST_APPLY:   state_d = ST_OUT;
			ST_OUT:     if (!sts.out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_wp    = wp_q;
		cmd.out_act  = act_q;
		cmd.out_sel  = sel_q;
		cmd.out_wp   = wp_q;
		cmd.out_hold = hold_q;
		mode_d       = mode_q;
		warm_d       = warm_q;
		wp_d         = wp_q;
		anchor_set_d = anchor_set_q;
		hold_d       = hold_q;
		hold_cnt_d   = hold_cnt_q;
		act_d        = act_q;
		sel_d        = sel_q;
		iter_d       = iter_q;
		unique case (state_q)
			ST_IDLE: cmd.accept = accept;
			ST_EVAL: begin
				sel_d = SEL_ZERO;
				if (warm_active) begin
					act_d = ACT_HEARTBEAT;
					if (sts.odom_seen) begin
						act_d  = ACT_SETPOINT;
						sel_d  = SEL_POS;
						warm_d = warm_q + 8'd1;
						if (!anchor_set_q) begin
							cmd.anchor_cap = 1'b1;
							anchor_set_d   = 1'b1;
						end
					end
				end else if (mode_q == MODE_INIT) begin
					act_d  = ACT_OFFBOARD;
					mode_d = MODE_OFFBOARD;
				end else if (mode_q == MODE_OFFBOARD) begin
					act_d  = ACT_ARM;
					mode_d = MODE_ARMED;
				end else if (wp_done) begin
					act_d = ACT_DONE;
				end else begin
					act_d = ACT_SETPOINT;
					if (!anchor_set_q) begin
						cmd.anchor_cap = 1'b1;
						anchor_set_d   = 1'b1;
					end
				end
			end
			ST_TGT: cmd.tgt_en  = 1'b1;
			ST_CHK: cmd.diff_en = 1'b1;
			ST_SQ:  cmd.sq_en   = 1'b1;
			ST_CMP: begin
				if (wp_q == WPW'(1) && !sts.gate_ok) begin
					sel_d = SEL_POS;
				end else begin
					if (hold_q) begin
						hold_cnt_d = hc_inc;
						if (hc_inc >= cfg.hold_ticks) begin
							wp_d         = wp_q + WPW'(1);
							anchor_set_d = 1'b0;
							hold_d       = 1'b0;
						end
					end else if (sts.reach) begin
						hold_d     = 1'b1;
						hold_cnt_d = '0;
					end
					sel_d = SEL_TGT;
				end
			end
			ST_NORM: cmd.norm_en = 1'b1;
			ST_MUL:  cmd.mul_en  = 1'b1;
			ST_SINIT: begin
				cmd.sqrt_init = 1'b1;
				iter_d        = '0;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q + ITW'(1);
			end
			ST_DINIT_A: begin
				cmd.div_init = 1'b1;
				iter_d       = '0;
			end
			ST_DIVA: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q + ITW'(1);
			end
			ST_DINIT_B: begin
				cmd.qa_store  = 1'b1;
				cmd.div_init  = 1'b1;
				cmd.div_sel_b = 1'b1;
				iter_d        = '0;
			end
			ST_DIVB: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q + ITW'(1);
			end
			ST_APPLY: begin
				cmd.apply_en = 1'b1;
				sel_d        = SEL_STEP;
			end
			ST_OUT: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_INIT;
			warm_q       <= '0;
			wp_q         <= '0;
			anchor_set_q <= 1'b0;
			hold_q       <= 1'b0;
			hold_cnt_q   <= '0;
			act_q        <= ACT_HEARTBEAT;
			sel_q        <= SEL_ZERO;
			iter_q       <= '0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			warm_q       <= warm_d;
			wp_q         <= wp_d;
			anchor_set_q <= anchor_set_d;
			hold_q       <= hold_d;
			hold_cnt_q   <= hold_cnt_d;
			act_q        <= act_d;
			sel_q        <= sel_d;
			iter_q       <= iter_d;
		end
	end

endmodule

FILE: hw/rtl/wsf_dp.sv
// Datapath: latched samples, waypoint table, reach test, sqrt and divide units, result register.
module wsf_dp
	import wsf_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  cfg_t                 cfg,
	output sts_t                 sts,
	input  logic                 req_type,
	input  logic [4:0]           wp_slot,
	input  logic signed [PW-1:0] wp_dx,
	input  logic signed [PW-1:0] wp_dy,
	input  logic signed [PW-1:0] wp_dz,
	input  logic signed [PW-1:0] pos_x,
	input  logic signed [PW-1:0] pos_y,
	input  logic signed [PW-1:0] pos_z,
	input  logic signed [15:0]   heading,
	input  logic                 odom_valid,
	input  logic signed [PW-1:0] follower_alt,
	input  logic                 follower_valid,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           action,
	output logic signed [PW-1:0] sp_x,
	output logic signed [PW-1:0] sp_y,
	output logic signed [PW-1:0] sp_z,
	output logic signed [15:0]   sp_heading,
	output logic [WPW-1:0]       wp_index,
	output logic                 is_holding
);

	localparam int AW = $clog2(MAX_WAYPOINTS);

	logic [3*PW-1:0] wp_mem [MAX_WAYPOINTS];
	logic [3*PW-1:0] rd_q;
	logic [31:0]     slot_ext, rd_ext;
	logic            wr_en;

	logic [PW-1:0] pos_x_q, pos_y_q, pos_z_q, anc_x_q, anc_y_q, anc_z_q;
	logic [15:0]   head_q;
	logic [PW-1:0] fol_q, base_q;
	logic          odom_seen_q, fol_seen_q;

	logic [PW-1:0] tgt_x_q, tgt_y_q, tgt_z_q;
	logic          gate_q;
	logic [33:0]   fz;
	logic [34:0]   fdiff, fmag;

	logic [PW:0]   dx, dy, dz;
	logic [PW:0]   ax_q, ay_q, ez_q;
	logic          xneg_q, yneg_q;
	logic [47:0]   ax2_q, ay2_q, ms2_q, th2_q;
	logic [48:0]   d2;
	logic          fits24;

	logic [1:0]    nsh;
	logic [29:0]   a_q, b_q;
	logic [59:0]   a2_q, b2_q;
	logic [53:0]   pa_q, pb_q;

	logic [60:0]   x_q, r_q, sbit_q, sq_t;
	logic [53:0]   num_q;
	logic [30:0]   rem_q;
	logic [31:0]   dv_t;
	logic [23:0]   qa_q;
	logic [PW-1:0] stp_x_q, stp_y_q;
	logic [PW:0]   sx_ext, sy_ext;

	logic          out_valid_q;
	logic [2:0]    action_q;
	logic [PW-1:0] spx_q, spy_q, spz_q;
	logic [15:0]   sph_q;
	logic [WPW-1:0] wpi_q;
	logic          hold_q;

	// waypoint table: one write port, one registered read port
	assign slot_ext = {27'b0, wp_slot};
	assign rd_ext   = {{(32 - WPW){1'b0}}, cmd.rd_wp};
	assign wr_en    = cmd.accept && req_type && (slot_ext < 32'(MAX_WAYPOINTS));

	always_ff @(posedge clk) begin
		if (wr_en)
			wp_mem[slot_ext[AW-1:0]] <= {wp_dz, wp_dy, wp_dx};
		rd_q <= wp_mem[rd_ext[AW-1:0]];
	end

	// latched samples and anchor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			head_q      <= '0;
			odom_seen_q <= 1'b0;
			fol_q       <= '0;
			base_q      <= '0;
			fol_seen_q  <= 1'b0;
			anc_x_q     <= '0;
			anc_y_q     <= '0;
			anc_z_q     <= '0;
		end else begin
			if (cmd.accept && !req_type) begin
				if (odom_valid) begin
					pos_x_q     <= pos_x;
					pos_y_q     <= pos_y;
					pos_z_q     <= pos_z;
					head_q      <= heading;
					odom_seen_q <= 1'b1;
				end
				if (follower_valid) begin
					fol_q <= follower_alt;
					if (!fol_seen_q) begin
						base_q     <= follower_alt;
						fol_seen_q <= 1'b1;
					end
				end
			end
			if (cmd.anchor_cap) begin
				anc_x_q <= pos_x_q;
				anc_y_q <= pos_y_q;
				anc_z_q <= pos_z_q;
			end
		end
	end

	// target and follower gate
	assign fz    = {{2{base_q[PW-1]}}, base_q} + {{10{cfg.alt_offset[23]}}, cfg.alt_offset};
	assign fdiff = {{3{fol_q[PW-1]}}, fol_q} - {fz[33], fz};
	assign fmag  = fdiff[34] ? (~fdiff + 35'd1) : fdiff;

	always_ff @(posedge clk) begin
		if (cmd.tgt_en) begin
			tgt_x_q <= sat_pos({anc_x_q[PW-1], anc_x_q} + {rd_q[PW-1], rd_q[PW-1:0]});
			tgt_y_q <= sat_pos({anc_y_q[PW-1], anc_y_q} + {rd_q[2*PW-1], rd_q[2*PW-1:PW]});
			tgt_z_q <= sat_pos({anc_z_q[PW-1], anc_z_q} + {rd_q[3*PW-1], rd_q[3*PW-1:2*PW]});
			gate_q  <= fol_seen_q && (fmag < {11'b0, cfg.alt_tol});
		end
	end

	// distance to target
	assign dx = {tgt_x_q[PW-1], tgt_x_q} - {pos_x_q[PW-1], pos_x_q};
	assign dy = {tgt_y_q[PW-1], tgt_y_q} - {pos_y_q[PW-1], pos_y_q};
	assign dz = {tgt_z_q[PW-1], tgt_z_q} - {pos_z_q[PW-1], pos_z_q};

	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			xneg_q <= dx[PW];
			yneg_q <= dy[PW];
			ax_q   <= dx[PW] ? (~dx + 1'b1) : dx;
			ay_q   <= dy[PW] ? (~dy + 1'b1) : dy;
			ez_q   <= dz[PW] ? (~dz + 1'b1) : dz;
		end
		if (cmd.sq_en) begin
			ax2_q <= 48'(ax_q[23:0]) * 48'(ax_q[23:0]);
			ay2_q <= 48'(ay_q[23:0]) * 48'(ay_q[23:0]);
			ms2_q <= 48'(cfg.step_len) * 48'(cfg.step_len);
			th2_q <= 48'(cfg.reach_th) * 48'(cfg.reach_th);
		end
	end

	// squares of the low 24 bits are exact whenever the magnitudes are below 2^24
	assign fits24 = (ax_q[PW:24] == '0) && (ay_q[PW:24] == '0);
	assign d2     = {1'b0, ax2_q} + {1'b0, ay2_q};

	// common right shift so that both magnitudes fit in 30 bits
	always_comb begin
		priority if (ax_q[PW:30] == '0 && ay_q[PW:30] == '0) nsh = 2'd0;
		else if (ax_q[PW:31] == '0 && ay_q[PW:31] == '0)     nsh = 2'd1;
		else if (ax_q[PW] == 1'b0 && ay_q[PW] == 1'b0)       nsh = 2'd2;
		else                                                 nsh = 2'd3;
	end

	always_ff @(posedge clk) begin
		if (cmd.norm_en) begin
			a_q <= 30'(ax_q >> nsh);
			b_q <= 30'(ay_q >> nsh);
		end
		if (cmd.mul_en) begin
			a2_q <= 60'(a_q) * 60'(a_q);
			b2_q <= 60'(b_q) * 60'(b_q);
			pa_q <= 54'(a_q) * 54'(cfg.step_len);
			pb_q <= 54'(b_q) * 54'(cfg.step_len);
		end
	end

	// bitwise integer square root, one result bit per cycle
	assign sq_t = r_q + sbit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			x_q    <= {1'b0, a2_q} + {1'b0, b2_q};
			r_q    <= '0;
			sbit_q <= 61'(1) << 60;
		end else if (cmd.sqrt_step) begin
			if (x_q >= sq_t) begin
				x_q <= x_q - sq_t;
				r_q <= (r_q >> 1) + sbit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// restoring divider by the root, one quotient bit per cycle
	assign dv_t = {rem_q, num_q[53]};

	always_ff @(posedge clk) begin
		if (cmd.qa_store)
			qa_q <= num_q[23:0];
		if (cmd.div_init) begin
			num_q <= cmd.div_sel_b ? pb_q : pa_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (dv_t >= {1'b0, r_q[30:0]}) begin
				rem_q <= 31'(dv_t - {1'b0, r_q[30:0]});
				num_q <= {num_q[52:0], 1'b1};
			end else begin
				rem_q <= dv_t[30:0];
				num_q <= {num_q[52:0], 1'b0};
			end
		end
	end

	assign sx_ext = {9'b0, qa_q};
	assign sy_ext = {9'b0, num_q[23:0]};

	always_ff @(posedge clk) begin
		if (cmd.apply_en) begin
			stp_x_q <= sat_pos({pos_x_q[PW-1], pos_x_q} + (xneg_q ? (~sx_ext + 1'b1) : sx_ext));
			stp_y_q <= sat_pos({pos_y_q[PW-1], pos_y_q} + (yneg_q ? (~sy_ext + 1'b1) : sy_ext));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			action_q <= cmd.out_act;
			wpi_q    <= cmd.out_wp;
			hold_q   <= cmd.out_hold;
			unique case (cmd.out_sel)
				SEL_ZERO: begin
					spx_q <= '0;
					spy_q <= '0;
					spz_q <= '0;
					sph_q <= '0;
				end
				SEL_POS: begin
					spx_q <= pos_x_q;
					spy_q <= pos_y_q;
					spz_q <= pos_z_q;
					sph_q <= head_q;
				end
				SEL_TGT: begin
					spx_q <= tgt_x_q;
					spy_q <= tgt_y_q;
					spz_q <= tgt_z_q;
					sph_q <= head_q;
				end
				SEL_STEP: begin
					spx_q <= stp_x_q;
					spy_q <= stp_y_q;
					spz_q <= tgt_z_q;
					sph_q <= head_q;
				end
				default: ;
			endcase
		end
	end

	assign sts.odom_seen = odom_seen_q;
	assign sts.gate_ok   = gate_q;
	assign sts.near      = fits24 && ((d2 <= {1'b0, ms2_q}) || (d2 < NEAR_ZERO_SQ));
	assign sts.reach     = (ax_q < {9'b0, cfg.reach_th}) && (ay_q < {9'b0, cfg.reach_th}) &&
		(ez_q < {9'b0, cfg.reach_th}) && (d2 < {1'b0, th2_q});
	assign sts.r_zero    = (r_q == '0);
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign sp_x       = spx_q;
	assign sp_y       = spy_q;
	assign sp_z       = spz_q;
	assign sp_heading = sph_q;
	assign wp_index   = wpi_q;
	assign is_holding = hold_q;

endmodule

FILE: hw/rtl/waypoint_step_follower.sv
// Waypoint follower with step-limited horizontal setpoint: top level.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | req_type, wp_*, pos_*, heading, follower_*
//   out     | output    | out_valid / out_stall | action, sp_*, sp_heading, wp_index, is_holding
//   cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A table-write transaction leaves the block idle. A tick goes from evaluation straight to the
// result register when no step is computed, through the distance test when the target is within
// one step, and also through a square root and two divisions, one bit per cycle, for a full step.
// Reset is asynchronous, active low, and clears all mission state; the table is not cleared.
// The next transaction is taken while a result waits in the output register; a result that
// is stalled holds the block in its output state until it is taken.
module waypoint_step_follower
	import wsf_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [4:0]           wp_slot,
	input  logic signed [PW-1:0] wp_dx,
	input  logic signed [PW-1:0] wp_dy,
	input  logic signed [PW-1:0] wp_dz,
	input  logic signed [PW-1:0] pos_x,
	input  logic signed [PW-1:0] pos_y,
	input  logic signed [PW-1:0] pos_z,
	input  logic signed [15:0]   heading,
	input  logic                 odom_valid,
	input  logic signed [PW-1:0] follower_alt,
	input  logic                 follower_valid,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           action,
	output logic signed [PW-1:0] sp_x,
	output logic signed [PW-1:0] sp_y,
	output logic signed [PW-1:0] sp_z,
	output logic signed [15:0]   sp_heading,
	output logic [WPW-1:0]       wp_index,
	output logic                 is_holding,
	input  logic                 cfg_write,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	wsf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wsf_ctrl #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.cfg      (cfg),
		.sts      (sts),
		.cmd      (cmd)
	);

	wsf_dp #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.sts            (sts),
		.req_type       (req_type),
		.wp_slot        (wp_slot),
		.wp_dx          (wp_dx),
		.wp_dy          (wp_dy),
		.wp_dz          (wp_dz),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.heading        (heading),
		.odom_valid     (odom_valid),
		.follower_alt   (follower_alt),
		.follower_valid (follower_valid),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.sp_x           (sp_x),
		.sp_y           (sp_y),
		.sp_z           (sp_z),
		.sp_heading     (sp_heading),
		.wp_index       (wp_index),
		.is_holding     (is_holding)
	);

endmodule
